>>> src/mmbt_pkg.sv
// Shared types and constants for the int32 matrix multiply (transposed B) unit.
`timescale 1ns / 1ps
`default_nettype none

package mmbt_pkg;

  // Field widths fixed by the word formats.
  localparam int IdxW  = 4;
  localparam int DataW = 32;

  // Default matrix dimensions.
  localparam int InnerLenDef = 16;
  localparam int OutColsDef  = 16;
  localparam int ARowsDef    = 16;

  // Storage sizes; the B store is addressed by {row, col}.
  localparam int BtDepth    = 256;
  localparam int RowDepth   = 16;
  localparam int QueueDepth = 4;

  // Action codes.
  localparam logic ACT_STORE_B = 1'b0;
  localparam logic ACT_STORE_A = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [DataW-1:0] elem_value;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         out_row;
    logic [IdxW-1:0]         out_col;
    logic signed [DataW-1:0] dot_sum;
    logic                    last_of_row;
  } out_word_t;

  // Command handed from the front end to the back end.
  typedef struct packed {
    logic             is_a;
    logic             row_end;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

>>> src/mmbt_front.sv
// Front end: checks each input word and turns legal ones into queue commands.
`timescale 1ns / 1ps
`default_nettype none

module mmbt_front #(
  parameter int INNER_LEN = mmbt_pkg::InnerLenDef,
  parameter int OUT_COLS  = mmbt_pkg::OutColsDef,
  parameter int A_ROWS    = mmbt_pkg::ARowsDef
) (
  input  logic               item_valid,
  output logic               item_ready,
  input  mmbt_pkg::in_word_t item,
  output logic               push_valid,
  input  logic               push_ready,
  output mmbt_pkg::cmd_t     push_cmd
);
  import mmbt_pkg::*;

  logic col_ok;
  logic row_ok;

  assign col_ok = 32'(item.col_index) < 32'(INNER_LEN);
  assign row_ok = (item.action == ACT_STORE_B) ? (32'(item.row_index) < 32'(OUT_COLS))
                                               : (32'(item.row_index) < 32'(A_ROWS));

  // Out-of-range words are taken and dropped here.
  assign item_ready = push_ready;
  assign push_valid = item_valid && col_ok && row_ok;

  always_comb begin
    push_cmd.is_a    = (item.action == ACT_STORE_A);
    push_cmd.row_end = (item.col_index == IdxW'(INNER_LEN - 1));
    push_cmd.row     = item.row_index;
    push_cmd.col     = item.col_index;
    push_cmd.value   = item.elem_value;
  end

endmodule

`default_nettype wire

>>> src/mmbt_queue.sv
// Small command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module mmbt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mmbt_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mmbt_pkg::cmd_t pop_cmd
);
  import mmbt_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cmd_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  logic            pop;

  assign push_ready = (count != (PtrW + 1)'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

>>> src/mmbt_back.sv
// Back end: performs stores and runs the multiply-accumulate for each result.
`timescale 1ns / 1ps
`default_nettype none

module mmbt_back #(
  parameter int INNER_LEN = mmbt_pkg::InnerLenDef,
  parameter int OUT_COLS  = mmbt_pkg::OutColsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  mmbt_pkg::cmd_t      cmd,
  output logic                result_valid,
  input  logic                result_ready,
  output mmbt_pkg::out_word_t result
);
  import mmbt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_t;

  state_t           state;
  logic [IdxW-1:0]  col_k;
  logic [IdxW-1:0]  pos_j;
  logic [IdxW-1:0]  row_q;
  logic             rd_valid;
  logic             mul_valid;
  logic [DataW-1:0] a_q;
  logic [DataW-1:0] b_q;
  logic [DataW-1:0] prod;
  logic [DataW-1:0] acc;
  logic             pop;
  logic             fire;

  logic [DataW-1:0] btrans [BtDepth];
  logic [DataW-1:0] arow   [RowDepth];

  assign cmd_ready = (state == S_IDLE);
  assign pop       = cmd_valid && cmd_ready;

  // The finished sum is loaded once the last product has landed and the output slot is free.
  assign fire = (state == S_DRAIN) && !rd_valid && !mul_valid &&
                (!result_valid || result_ready);

  // Storage writes, registered reads and the registered product.
  always_ff @(posedge clk) begin
    if (pop && !cmd.is_a) btrans[{cmd.row, cmd.col}] <= cmd.value;
    if (pop && cmd.is_a) arow[cmd.col] <= cmd.value;
    b_q  <= btrans[{col_k, pos_j}];
    a_q  <= arow[pos_j];
    prod <= a_q * b_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_valid     <= 1'b0;
      mul_valid    <= 1'b0;
      result_valid <= 1'b0;
      col_k        <= '0;
      pos_j        <= '0;
    end else begin
      rd_valid  <= (state == S_RUN);
      mul_valid <= rd_valid;
      if (mul_valid) acc <= acc + prod;
      if (result_valid && result_ready && !fire) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop && cmd.is_a && cmd.row_end) begin
            row_q <= cmd.row;
            col_k <= '0;
            pos_j <= '0;
            acc   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (pos_j == IdxW'(INNER_LEN - 1)) begin
            state <= S_DRAIN;
          end else begin
            pos_j <= pos_j + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait for the last product to land and for the output slot to free.
          if (fire) begin
            result_valid       <= 1'b1;
            result.out_row     <= row_q;
            result.out_col     <= col_k;
            result.dot_sum     <= acc;
            result.last_of_row <= (col_k == IdxW'(OUT_COLS - 1));
            acc                <= '0;
            pos_j              <= '0;
            if (col_k == IdxW'(OUT_COLS - 1)) begin
              state <= S_IDLE;
            end else begin
              col_k <= col_k + 1'b1;
              state <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/int32_matrix_multiply_bt_unit.sv
// Top level of the signed 32-bit matrix multiply unit with transposed B storage.
//
// Usage: words enter on item_valid/item_ready. A word with action store-B writes one
// element of the transposed-B store at {row_index, col_index}; a word with action
// store-A writes one element of the current A row. The A word in the last inner
// position triggers OUT_COLS result words on result_valid/result_ready, one dot
// product per B column in ascending order, the final one marked last_of_row.
// Words with an out-of-range row or column are accepted and dropped.
// Flow: a combinational front end checks each word and pushes it into a
// four-entry command queue, so input words are taken while the back end is busy
// until the queue fills. Each result comes from the single multiply-accumulate
// chain (B store read, registered product, add); the back end takes a new
// command, store words included, only while it is idle between rows.
// Sums wrap modulo 2^32. Stored elements are undefined until written.
// Reset clears the queue and the sequencer; no result word is valid after reset.
// When the receiver stalls, the finished word holds in the output register, the
// back end waits before loading the next one, and the queue absorbs new words.
`timescale 1ns / 1ps
`default_nettype none

module int32_matrix_multiply_bt_unit #(
  parameter int INNER_LEN = mmbt_pkg::InnerLenDef,
  parameter int OUT_COLS  = mmbt_pkg::OutColsDef,
  parameter int A_ROWS    = mmbt_pkg::ARowsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  mmbt_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output mmbt_pkg::out_word_t result
);
  import mmbt_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  mmbt_front #(
    .INNER_LEN(INNER_LEN),
    .OUT_COLS (OUT_COLS),
    .A_ROWS   (A_ROWS)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  mmbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  mmbt_back #(
    .INNER_LEN(INNER_LEN),
    .OUT_COLS (OUT_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // No result word survives reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // The last flag marks exactly the final column of a row.
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_of_row == (result.out_col == IdxW'(OUT_COLS - 1))))
    else $error("last_of_row does not match final column");

  // After a row ends the sequencer must go idle and fetch a new command first.
  a_gap_after_row: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result.last_of_row) |=> !result_valid)
    else $error("result word issued straight after end of row");

endmodule

`default_nettype wire
